### hdl/uvs_pkg.sv
// shared types, register codes and constants for the uv sphere vertex generator
// no dependencies; every module of the block imports this package
package uvs_pkg;

   // configuration limits and pipeline depths
   localparam int MAX_PRECISION = 1024;
   localparam int PH_LAT        = 3;
   localparam int SC_LAT        = 36;
   localparam int NUM_TERMS     = 11;

   // pi/2 in Q30 and one in Q30
   localparam logic [30:0] HALFPI_Q30 = 31'd1686629713;
   localparam logic [31:0] ONE_Q30    = 32'h4000_0000;

   // configuration register indexes
   typedef enum logic [2:0] {
      REG_CENTER_X  = 3'd0,
      REG_CENTER_Y  = 3'd1,
      REG_CENTER_Z  = 3'd2,
      REG_RADIUS    = 3'd3,
      REG_PRECISION = 3'd4
   } csr_reg_type;

   // reciprocal divider sequencer
   typedef enum logic {
      DIV_IDLE,
      DIV_RUN
   } div_state_type;

   // one vertex slot issued into the pipeline
   typedef struct packed {
      logic [9:0]  k;
      logic [10:0] j;
      logic        last;
      logic        off;
   } slot_type;

   // flags that travel beside the data
   typedef struct packed {
      logic valid;
      logic last;
      logic off;
   } flag_type;

   // flags plus texture coordinates
   typedef struct packed {
      logic        valid;
      logic        last;
      logic        off;
      logic [16:0] tex_s;
      logic [16:0] tex_t;
   } side_type;

   // one finished vertex
   typedef struct packed {
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [31:0] pos_z;
      logic [17:0] normal_x;
      logic [17:0] normal_y;
      logic [17:0] normal_z;
      logic [16:0] tex_s;
      logic [16:0] tex_t;
      logic        last_of_pair;
      logic        off_mesh;
   } vtx_type;

   // taylor divisors of term n
   function automatic int sin_div(input int n);
      return 2 * n * (2 * n + 1);
   endfunction

   function automatic int cos_div(input int n);
      return (2 * n - 1) * (2 * n);
   endfunction

endpackage

### hdl/uvs_recip.sv
// bit-serial divider producing 2^32 / precision as quotient and remainder
// depends on uvs_pkg for the sequencer state type
module uvs_recip (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [11:0] divisor,
   output logic        busy,
   output logic [31:0] quo,
   output logic [11:0] rem
);
   import uvs_pkg::*;

   div_state_type state_ff, state_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic [12:0]   rem_ff, rem_in;
   logic [32:0]   quo_ff, quo_in;
   logic [12:0]   shifted;
   logic          ge;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         DIV_IDLE: begin
            if (start) state_in = DIV_RUN;
         end
         DIV_RUN: begin
            if (start) state_in = DIV_RUN;
            else if (cnt_ff == 6'd32) state_in = DIV_IDLE;
         end
         default: state_in = DIV_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      busy = (state_ff == DIV_RUN);
   end

   // one quotient bit per cycle; the dividend is a single one at bit 32
   always_comb begin
      shifted = {rem_ff[11:0], (cnt_ff == 6'd0)};
      ge      = (shifted >= {1'b0, divisor});
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         cnt_in = 6'd0;
         rem_in = 13'd0;
         quo_in = 33'd0;
      end else if (state_ff == DIV_RUN) begin
         cnt_in = cnt_ff + 6'd1;
         rem_in = ge ? (shifted - {1'b0, divisor}) : shifted;
         quo_in = {quo_ff[31:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_RUN;
         cnt_ff   <= 6'd0;
         rem_ff   <= 13'd0;
         quo_ff   <= 33'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         rem_ff   <= rem_in;
         quo_ff   <= quo_in;
      end
   end

   assign quo = quo_ff[31:0];
   assign rem = rem_ff[11:0];

endmodule

### hdl/uvs_feed.sv
// input holding register that splits each on-mesh transfer into two vertex slots, an off-mesh one into one
// depends on uvs_pkg for the slot type and the precision limit
module uvs_feed (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic [8:0]      req_ring_index,
   input  logic [10:0]     req_segment_index,
   input  logic [11:0]     pabs,
   input  logic            hold,
   input  logic            adv,
   output logic            slot_valid,
   output uvs_pkg::slot_type slot
);
   import uvs_pkg::*;

   logic        item_v_ff, item_v_in;
   logic        sub_ff, sub_in;
   logic [8:0]  ring_ff, ring_in;
   logic [10:0] seg_ff, seg_in;
   logic        off;
   logic        last_now;
   logic        take;

   // mesh bounds check
   always_comb begin
      off = (pabs < 12'd2) || (pabs > 12'(MAX_PRECISION)) ||
            (12'(ring_ff) >= (pabs >> 1)) || (12'(seg_ff) > pabs);
      last_now = off || sub_ff;
   end

   assign req_ready = !hold && (!item_v_ff || (adv && last_now));
   assign take      = req_valid && req_ready;

   // upper vertex first, then lower; an off-mesh item gives one slot
   always_comb begin
      item_v_in = item_v_ff;
      sub_in    = sub_ff;
      ring_in   = ring_ff;
      seg_in    = seg_ff;
      if (item_v_ff && adv) begin
         if (last_now) begin
            item_v_in = 1'b0;
            sub_in    = 1'b0;
         end else begin
            sub_in = 1'b1;
         end
      end
      if (take) begin
         item_v_in = 1'b1;
         sub_in    = 1'b0;
         ring_in   = req_ring_index;
         seg_in    = req_segment_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_v_ff <= 1'b0;
         sub_ff    <= 1'b0;
      end else begin
         item_v_ff <= item_v_in;
         sub_ff    <= sub_in;
      end
      ring_ff <= ring_in;
      seg_ff  <= seg_in;
   end

   // slot fields
   always_comb begin
      slot_valid = item_v_ff;
      slot.k     = sub_ff ? {1'b0, ring_ff} : ({1'b0, ring_ff} + 10'd1);
      slot.j     = seg_ff;
      slot.last  = last_now;
      slot.off   = off;
   end

endmodule

### hdl/uvs_phase.sv
// three-stage unit: turn phases k/p and j/p in Q0.32 and texture coordinates
// divides by precision through the reciprocal given on quo and rem; depends on uvs_pkg
module uvs_phase (
   input  logic        clock,
   input  logic        en,
   input  logic [9:0]  k,
   input  logic [10:0] j,
   input  logic [11:0] pabs,
   input  logic [31:0] quo,
   input  logic [11:0] rem,
   output logic [31:0] phase_lat,
   output logic [31:0] phase_lon,
   output logic [16:0] tex_s,
   output logic [16:0] tex_t
);
   import uvs_pkg::*;

   // numerators: k*rem, j*rem, j<<16, k<<17, each plus p/2
   logic [26:0] m1_ff [0:3];
   logic [26:0] m1_in [0:3];
   logic [31:0] kq1_ff, jq1_ff;
   logic [26:0] m2_ff [0:3];
   logic [26:0] e2_ff [0:3];
   logic [26:0] e2_in [0:3];
   logic [31:0] kq2_ff, jq2_ff;
   logic [26:0] f3 [0:3];
   logic [38:0] rr [0:3];
   logic [31:0] phase_lat_ff, phase_lon_ff;
   logic [16:0] tex_s_ff, tex_t_ff;
   logic [26:0] half;

   // stage 1: numerators and whole-turn parts
   always_comb begin
      half     = 27'(pabs >> 1);
      m1_in[0] = 27'(27'(k) * 27'(rem)) + half;
      m1_in[1] = 27'(27'(j) * 27'(rem)) + half;
      m1_in[2] = {j, 16'd0} + half;
      m1_in[3] = {k, 17'd0} + half;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int n = 0; n < 4; n++) m1_ff[n] <= m1_in[n];
         kq1_ff <= 32'(k) * quo;
         jq1_ff <= 32'(j) * quo;
      end
   end

   // stage 2: quotient estimate by reciprocal multiply
   always_comb begin
      for (int n = 0; n < 4; n++) begin
         e2_in[n] = 27'((59'(m1_ff[n]) * 59'(quo)) >> 32);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int n = 0; n < 4; n++) begin
            m2_ff[n] <= m1_ff[n];
            e2_ff[n] <= e2_in[n];
         end
         kq2_ff <= kq1_ff;
         jq2_ff <= jq1_ff;
      end
   end

   // stage 3: the estimate is at most one low, fix with one compare
   always_comb begin
      for (int n = 0; n < 4; n++) begin
         rr[n] = 39'(m2_ff[n]) - 39'(e2_ff[n]) * 39'(pabs);
         f3[n] = e2_ff[n] + 27'(rr[n] >= 39'(pabs));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         phase_lat_ff <= kq2_ff + 32'(f3[0]);
         phase_lon_ff <= jq2_ff + 32'(f3[1]);
         tex_s_ff     <= f3[2][16:0];
         tex_t_ff     <= f3[3][16:0];
      end
   end

   assign phase_lat = phase_lat_ff;
   assign phase_lon = phase_lon_ff;
   assign tex_s     = tex_s_ff;
   assign tex_t     = tex_t_ff;

endmodule

### hdl/uvs_sincos.sv
// pipelined sine and cosine of a Q0.32 phase by truncated taylor series in Q30
// three stages per term, 36 stages in all; depends on uvs_pkg
module uvs_sincos (
   input  logic               clock,
   input  logic               en,
   input  logic [31:0]        phase,
   output logic signed [31:0] sn,
   output logic signed [31:0] cs
);
   import uvs_pkg::*;

   // values at term boundaries, index 0 after the prelude
   logic [31:0]        ts_b [0:NUM_TERMS];
   logic [31:0]        tc_b [0:NUM_TERMS];
   logic signed [33:0] ss_b [0:NUM_TERMS];
   logic signed [33:0] cc_b [0:NUM_TERMS];
   logic [31:0]        x2_b [0:NUM_TERMS];
   logic [1:0]         q_b  [0:NUM_TERMS];

   logic [1:0]         q0_ff;
   logic [30:0]        x_ff, x_in;
   logic [31:0]        x2_in;

   // prelude: angle in radians, then its square
   assign x_in  = 31'((61'(phase[29:0]) * 61'(HALFPI_Q30)) >> 30);
   assign x2_in = 32'((62'(x_ff) * 62'(x_ff)) >> 30);

   always_ff @(posedge clock) begin
      if (en) begin
         q0_ff   <= phase[31:30];
         x_ff    <= x_in;
         ts_b[0] <= 32'(x_ff);
         tc_b[0] <= ONE_Q30;
         ss_b[0] <= 34'(x_ff);
         cc_b[0] <= 34'(ONE_Q30);
         x2_b[0] <= x2_in;
         q_b[0]  <= q0_ff;
      end
   end

   // series terms
   for (genvar n = 1; n <= NUM_TERMS; n++) begin : g_term
      localparam int          SD = sin_div(n);
      localparam int          CD = cos_div(n);
      localparam logic [31:0] SM = 32'((64'd1 << 32) / SD);
      localparam logic [31:0] CM = 32'((64'd1 << 32) / CD);

      logic [31:0]        ya_s_ff, ya_c_ff, ya_s_in, ya_c_in;
      logic signed [33:0] ssa_ff, cca_ff, ssb_ff, ccb_ff;
      logic [31:0]        x2a_ff, x2b_ff;
      logic [1:0]         qa_ff, qb_ff;
      logic [31:0]        yb_s_ff, yb_c_ff, eb_s_ff, eb_c_ff, eb_s_in, eb_c_in;
      logic [40:0]        rr_s, rr_c;
      logic [31:0]        t_s, t_c;

      // term times x^2
      assign ya_s_in = 32'((64'(ts_b[n-1]) * 64'(x2_b[n-1])) >> 30);
      assign ya_c_in = 32'((64'(tc_b[n-1]) * 64'(x2_b[n-1])) >> 30);

      always_ff @(posedge clock) begin
         if (en) begin
            ya_s_ff <= ya_s_in;
            ya_c_ff <= ya_c_in;
            ssa_ff  <= ss_b[n-1];
            cca_ff  <= cc_b[n-1];
            x2a_ff  <= x2_b[n-1];
            qa_ff   <= q_b[n-1];
         end
      end

      // reciprocal multiply for the divisor
      assign eb_s_in = 32'((64'(ya_s_ff) * 64'(SM)) >> 32);
      assign eb_c_in = 32'((64'(ya_c_ff) * 64'(CM)) >> 32);

      always_ff @(posedge clock) begin
         if (en) begin
            yb_s_ff <= ya_s_ff;
            yb_c_ff <= ya_c_ff;
            eb_s_ff <= eb_s_in;
            eb_c_ff <= eb_c_in;
            ssb_ff  <= ssa_ff;
            ccb_ff  <= cca_ff;
            x2b_ff  <= x2a_ff;
            qb_ff   <= qa_ff;
         end
      end

      // correct the truncated quotient and accumulate
      always_comb begin
         rr_s = 41'(yb_s_ff) - 41'(eb_s_ff) * 41'(SD);
         rr_c = 41'(yb_c_ff) - 41'(eb_c_ff) * 41'(CD);
         t_s  = eb_s_ff + 32'(rr_s >= 41'(SD));
         t_c  = eb_c_ff + 32'(rr_c >= 41'(CD));
      end

      always_ff @(posedge clock) begin
         if (en) begin
            ts_b[n] <= t_s;
            tc_b[n] <= t_c;
            ss_b[n] <= (n % 2 == 1) ? (ssb_ff - 34'(t_s)) : (ssb_ff + 34'(t_s));
            cc_b[n] <= (n % 2 == 1) ? (ccb_ff - 34'(t_c)) : (ccb_ff + 34'(t_c));
            x2_b[n] <= x2b_ff;
            q_b[n]  <= qb_ff;
         end
      end
   end

   // clamp to [0, 1] and unfold the quadrant
   logic [31:0]        s_cl, c_cl;
   logic signed [31:0] sn_in, cs_in;
   logic signed [31:0] sn_ff, cs_ff;

   always_comb begin
      if (ss_b[NUM_TERMS][33]) s_cl = 32'd0;
      else if (34'(ss_b[NUM_TERMS]) > 34'(ONE_Q30)) s_cl = ONE_Q30;
      else s_cl = 32'(ss_b[NUM_TERMS]);
      if (cc_b[NUM_TERMS][33]) c_cl = 32'd0;
      else if (34'(cc_b[NUM_TERMS]) > 34'(ONE_Q30)) c_cl = ONE_Q30;
      else c_cl = 32'(cc_b[NUM_TERMS]);
      case (q_b[NUM_TERMS])
         2'd0: begin
            sn_in = s_cl;
            cs_in = c_cl;
         end
         2'd1: begin
            sn_in = c_cl;
            cs_in = -s_cl;
         end
         2'd2: begin
            sn_in = -s_cl;
            cs_in = -c_cl;
         end
         default: begin
            sn_in = -c_cl;
            cs_in = s_cl;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sn_ff <= sn_in;
         cs_ff <= cs_in;
      end
   end

   assign sn = sn_ff;
   assign cs = cs_ff;

endmodule

### hdl/uv_sphere_vertex_generator_core.sv
// Each on-mesh index pair gives two vertices on the one result channel, an off-mesh
// pair gives one; pairs overlap in the pipeline. A single global stall holds the 44-stage path.
// Reset: registers take their reset values; the reciprocal divider then runs
// with req_ready low, and again after every precision write.
// depends on uvs_pkg, uvs_recip, uvs_feed, uvs_phase, uvs_sincos
module uv_sphere_vertex_generator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [8:0]  req_ring_index,
   input  logic [10:0] req_segment_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_pos_x,
   output logic [31:0] rsp_pos_y,
   output logic [31:0] rsp_pos_z,
   output logic [17:0] rsp_normal_x,
   output logic [17:0] rsp_normal_y,
   output logic [17:0] rsp_normal_z,
   output logic [16:0] rsp_tex_s,
   output logic [16:0] rsp_tex_t,
   output logic        rsp_last_of_pair,
   output logic        rsp_off_mesh,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import uvs_pkg::*;

   // configuration registers
   logic signed [31:0] cx_ff, cy_ff, cz_ff, radius_ff;
   logic signed [11:0] prec_ff;
   logic [11:0]        pabs;
   logic [31:0]        rmag;
   logic               div_start;

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff     <= 32'sd0;
         cy_ff     <= 32'sd0;
         cz_ff     <= 32'sd0;
         radius_ff <= 32'sd65536;
         prec_ff   <= 12'sd100;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_CENTER_X:  cx_ff     <= csr_wdata;
            REG_CENTER_Y:  cy_ff     <= csr_wdata;
            REG_CENTER_Z:  cz_ff     <= csr_wdata;
            REG_RADIUS:    radius_ff <= csr_wdata;
            REG_PRECISION: prec_ff   <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   assign pabs      = prec_ff[11] ? 12'(-prec_ff) : 12'(prec_ff);
   assign rmag      = radius_ff[31] ? 32'(-radius_ff) : 32'(radius_ff);
   assign div_start = csr_we && (csr_index == REG_PRECISION);

   // reciprocal of the precision
   logic        div_busy;
   logic [31:0] quo;
   logic [11:0] rem;

   uvs_recip u_recip (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .divisor (pabs),
      .busy    (div_busy),
      .quo     (quo),
      .rem     (rem)
   );

   // global advance: the output queue has room or is being drained
   logic [1:0] cnt_ff, cnt_in;
   logic       adv;

   assign adv = (cnt_ff != 2'd2) || rsp_ready;

   // input transfer and slot issue
   logic     slot_valid;
   slot_type slot;

   uvs_feed u_feed (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_ring_index    (req_ring_index),
      .req_segment_index (req_segment_index),
      .pabs              (pabs),
      .hold              (div_busy),
      .adv               (adv),
      .slot_valid        (slot_valid),
      .slot              (slot)
   );

   // phases and texture
   logic [31:0] phase_lat, phase_lon;
   logic [16:0] tex_s, tex_t;

   uvs_phase u_phase (
      .clock     (clock),
      .en        (adv),
      .k         (slot.k),
      .j         (slot.j),
      .pabs      (pabs),
      .quo       (quo),
      .rem       (rem),
      .phase_lat (phase_lat),
      .phase_lon (phase_lon),
      .tex_s     (tex_s),
      .tex_t     (tex_t)
   );

   // flags beside the phase unit
   flag_type sa_ff [0:PH_LAT-1];
   flag_type sa_in;

   always_comb begin
      sa_in.valid = slot_valid;
      sa_in.last  = slot.last;
      sa_in.off   = slot.off;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < PH_LAT; n++) sa_ff[n] <= '0;
      end else if (adv) begin
         sa_ff[0] <= sa_in;
         for (int n = 1; n < PH_LAT; n++) sa_ff[n] <= sa_ff[n-1];
      end
   end

   // sine and cosine of latitude and longitude
   logic signed [31:0] lat_sn, lat_cs, lon_sn, lon_cs;

   uvs_sincos u_sc_lat (
      .clock (clock),
      .en    (adv),
      .phase (phase_lat),
      .sn    (lat_sn),
      .cs    (lat_cs)
   );

   uvs_sincos u_sc_lon (
      .clock (clock),
      .en    (adv),
      .phase (phase_lon),
      .sn    (lon_sn),
      .cs    (lon_cs)
   );

   // side data beside the sine and cosine units
   side_type sb_ff [0:SC_LAT-1];
   side_type sb_in;

   always_comb begin
      sb_in.valid = sa_ff[PH_LAT-1].valid;
      sb_in.last  = sa_ff[PH_LAT-1].last;
      sb_in.off   = sa_ff[PH_LAT-1].off;
      sb_in.tex_s = tex_s;
      sb_in.tex_t = tex_t;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < SC_LAT; n++) sb_ff[n].valid <= 1'b0;
      end else if (adv) begin
         sb_ff[0].valid <= sb_in.valid;
         for (int n = 1; n < SC_LAT; n++) sb_ff[n].valid <= sb_ff[n-1].valid;
      end
      if (adv) begin
         sb_ff[0].last  <= sb_in.last;
         sb_ff[0].off   <= sb_in.off;
         sb_ff[0].tex_s <= sb_in.tex_s;
         sb_ff[0].tex_t <= sb_in.tex_t;
         for (int n = 1; n < SC_LAT; n++) begin
            sb_ff[n].last  <= sb_ff[n-1].last;
            sb_ff[n].off   <= sb_ff[n-1].off;
            sb_ff[n].tex_s <= sb_ff[n-1].tex_s;
            sb_ff[n].tex_t <= sb_ff[n-1].tex_t;
         end
      end
   end

   // normal products: cos(lat) = sin of phase, sin(lat) = -cos of phase
   logic [30:0]        clat_m, clon_m, slon_m;
   logic [61:0]        px_ff, py_ff, px_in, py_in;
   logic               sx_ff, sy_ff;
   logic signed [31:0] slat_ff;
   side_type           n1_ff;

   always_comb begin
      clat_m = lat_sn[31] ? 31'(-lat_sn) : 31'(lat_sn);
      clon_m = lon_cs[31] ? 31'(-lon_cs) : 31'(lon_cs);
      slon_m = lon_sn[31] ? 31'(-lon_sn) : 31'(lon_sn);
      px_in  = 62'(clat_m) * 62'(clon_m);
      py_in  = 62'(clat_m) * 62'(slon_m);
   end

   always_ff @(posedge clock) begin
      if (reset) n1_ff.valid <= 1'b0;
      else if (adv) n1_ff.valid <= sb_ff[SC_LAT-1].valid;
      if (adv) begin
         px_ff   <= px_in;
         py_ff   <= py_in;
         sx_ff   <= lat_sn[31] ^ lon_cs[31];
         sy_ff   <= lat_sn[31] ^ lon_sn[31];
         slat_ff <= -lat_cs;
         n1_ff.last  <= sb_ff[SC_LAT-1].last;
         n1_ff.off   <= sb_ff[SC_LAT-1].off;
         n1_ff.tex_s <= sb_ff[SC_LAT-1].tex_s;
         n1_ff.tex_t <= sb_ff[SC_LAT-1].tex_t;
      end
   end

   // round normals to Q16, half away from zero
   logic [16:0] nm_in [0:2];
   logic        ng_in [0:2];
   logic [16:0] nm_ff [0:2];
   logic        ng_ff [0:2];
   logic [17:0] n18_ff [0:2];
   logic [30:0] slat_m;
   side_type    n2_ff;

   always_comb begin
      slat_m   = slat_ff[31] ? 31'(-slat_ff) : 31'(slat_ff);
      nm_in[0] = 17'((px_ff + 62'(64'd1 << 43)) >> 44);
      nm_in[1] = 17'((py_ff + 62'(64'd1 << 43)) >> 44);
      nm_in[2] = 17'((slat_m + 31'(32'd1 << 13)) >> 14);
      ng_in[0] = sx_ff;
      ng_in[1] = sy_ff;
      ng_in[2] = slat_ff[31];
   end

   always_ff @(posedge clock) begin
      if (reset) n2_ff.valid <= 1'b0;
      else if (adv) n2_ff.valid <= n1_ff.valid;
      if (adv) begin
         for (int n = 0; n < 3; n++) begin
            nm_ff[n]  <= nm_in[n];
            ng_ff[n]  <= ng_in[n];
            n18_ff[n] <= ng_in[n] ? 18'(-{1'b0, nm_in[n]}) : {1'b0, nm_in[n]};
         end
         n2_ff.last  <= n1_ff.last;
         n2_ff.off   <= n1_ff.off;
         n2_ff.tex_s <= n1_ff.tex_s;
         n2_ff.tex_t <= n1_ff.tex_t;
      end
   end

   // radius times normal
   logic [48:0] pr_ff [0:2];
   logic        pg1_ff [0:2];
   logic [17:0] pn1_ff [0:2];
   side_type    p1_ff;

   always_ff @(posedge clock) begin
      if (reset) p1_ff.valid <= 1'b0;
      else if (adv) p1_ff.valid <= n2_ff.valid;
      if (adv) begin
         for (int n = 0; n < 3; n++) begin
            pr_ff[n]  <= 49'(rmag) * 49'(nm_ff[n]);
            pg1_ff[n] <= ng_ff[n];
            pn1_ff[n] <= n18_ff[n];
         end
         p1_ff.last  <= n2_ff.last;
         p1_ff.off   <= n2_ff.off;
         p1_ff.tex_s <= n2_ff.tex_s;
         p1_ff.tex_t <= n2_ff.tex_t;
      end
   end

   // round the offset at 16 fractional bits
   logic [32:0]        rnd [0:2];
   logic signed [33:0] off_ff [0:2];
   logic [17:0]        pn2_ff [0:2];
   side_type           p2_ff;

   always_comb begin
      for (int n = 0; n < 3; n++) rnd[n] = 33'((pr_ff[n] + 49'(32'd1 << 15)) >> 16);
   end

   always_ff @(posedge clock) begin
      if (reset) p2_ff.valid <= 1'b0;
      else if (adv) p2_ff.valid <= p1_ff.valid;
      if (adv) begin
         for (int n = 0; n < 3; n++) begin
            off_ff[n] <= pg1_ff[n] ? -$signed({1'b0, rnd[n]}) : $signed({1'b0, rnd[n]});
            pn2_ff[n] <= pn1_ff[n];
         end
         p2_ff.last  <= p1_ff.last;
         p2_ff.off   <= p1_ff.off;
         p2_ff.tex_s <= p1_ff.tex_s;
         p2_ff.tex_t <= p1_ff.tex_t;
      end
   end

   // add the center, saturate, and zero an off-mesh vertex
   logic signed [31:0] cent [0:2];
   logic signed [34:0] sum [0:2];
   logic [31:0]        pos [0:2];
   vtx_type            p3_in, p3_ff;
   logic               p3_valid_ff;

   always_comb begin
      cent[0] = cx_ff;
      cent[1] = cy_ff;
      cent[2] = cz_ff;
      for (int n = 0; n < 3; n++) begin
         sum[n] = 35'(cent[n]) + 35'(off_ff[n]);
         if (sum[n] > 35'sd2147483647) pos[n] = 32'h7FFF_FFFF;
         else if (sum[n] < -35'sd2147483648) pos[n] = 32'h8000_0000;
         else pos[n] = sum[n][31:0];
      end
      p3_in = '0;
      p3_in.last_of_pair = p2_ff.last;
      p3_in.off_mesh     = p2_ff.off;
      if (!p2_ff.off) begin
         p3_in.pos_x    = pos[0];
         p3_in.pos_y    = pos[1];
         p3_in.pos_z    = pos[2];
         p3_in.normal_x = pn2_ff[0];
         p3_in.normal_y = pn2_ff[1];
         p3_in.normal_z = pn2_ff[2];
         p3_in.tex_s    = p2_ff.tex_s;
         p3_in.tex_t    = p2_ff.tex_t;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) p3_valid_ff <= 1'b0;
      else if (adv) p3_valid_ff <= p2_ff.valid;
      if (adv) p3_ff <= p3_in;
   end

   // two-entry output queue parts the pipeline from the result channel
   vtx_type q_ff [0:1];
   logic    wr_ff, wr_in, rd_ff, rd_in;
   logic    push, pop;

   assign push = adv && p3_valid_ff;
   assign pop  = rsp_valid && rsp_ready;

   always_comb begin
      wr_in  = push ? !wr_ff : wr_ff;
      rd_in  = pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) q_ff[wr_ff] <= p3_ff;
   end

   assign rsp_valid        = (cnt_ff != 2'd0);
   assign rsp_pos_x        = q_ff[rd_ff].pos_x;
   assign rsp_pos_y        = q_ff[rd_ff].pos_y;
   assign rsp_pos_z        = q_ff[rd_ff].pos_z;
   assign rsp_normal_x     = q_ff[rd_ff].normal_x;
   assign rsp_normal_y     = q_ff[rd_ff].normal_y;
   assign rsp_normal_z     = q_ff[rd_ff].normal_z;
   assign rsp_tex_s        = q_ff[rd_ff].tex_s;
   assign rsp_tex_t        = q_ff[rd_ff].tex_t;
   assign rsp_last_of_pair = q_ff[rd_ff].last_of_pair;
   assign rsp_off_mesh     = q_ff[rd_ff].off_mesh;

   // checks
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("output queue count out of range");

   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> !div_busy)
      else $error("input transfer while reciprocal is busy");

   a_off_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_off_mesh) |-> rsp_last_of_pair)
      else $error("off-mesh vertex does not end its item");

   a_off_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_off_mesh) |-> (rsp_pos_x == 32'd0 && rsp_tex_s == 17'd0 &&
                                       rsp_normal_z == 18'd0))
      else $error("off-mesh vertex carries data");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2 && !rsp_ready) |=> (cnt_ff == 2'd2))
      else $error("full queue changed without a transfer");

endmodule

### dv/uvs_checker.sv
// checker for the uv sphere vertex generator: predicts vertices per index pair
// and compares them with every rsp_ transfer; depends on uvs_pkg
module uvs_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [8:0]  req_ring_index,
   input  logic [10:0] req_segment_index,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_pos_x,
   input  logic [31:0] rsp_pos_y,
   input  logic [31:0] rsp_pos_z,
   input  logic [17:0] rsp_normal_x,
   input  logic [17:0] rsp_normal_y,
   input  logic [17:0] rsp_normal_z,
   input  logic [16:0] rsp_tex_s,
   input  logic [16:0] rsp_tex_t,
   input  logic        rsp_last_of_pair,
   input  logic        rsp_off_mesh,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output int          fail_count,
   output int          pending_vertices
);

   timeunit 1ns;
   timeprecision 1ps;

   import uvs_pkg::*;

   // mirrored configuration
   logic signed [31:0] cfg_cx, cfg_cy, cfg_cz, cfg_r;
   logic signed [11:0] cfg_p;

   vtx_type vertex_q[$];

   assign pending_vertices = vertex_q.size();

   // round a signed value right by sh, half away from zero
   function automatic longint round_away(input longint v, input int sh);
      longint half;
      half = longint'(1) << (sh - 1);
      if (v < 0) return -((-v + half) >>> sh);
      return (v + half) >>> sh;
   endfunction

   // taylor sine/cosine of a turn fraction, both in Q30
   function automatic void turn_sincos(input logic [31:0] ph, output longint sn,
                                       output longint cs);
      logic [1:0] quad;
      logic [63:0] x, x2, ts, tc;
      longint ss, cc, s, c;
      quad = ph[31:30];
      x = ({34'd0, ph[29:0]} * 64'd1686629713) >> 30;
      x2 = (x * x) >> 30;
      ts = x;
      tc = 64'd1073741824;
      ss = longint'(x);
      cc = 64'sd1073741824;
      for (int n = 1; n <= 11; n++) begin
         ts = ((ts * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
         tc = ((tc * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
         if (n % 2 == 1) begin
            ss -= longint'(ts);
            cc -= longint'(tc);
         end else begin
            ss += longint'(ts);
            cc += longint'(tc);
         end
      end
      s = ss < 0 ? 0 : (ss > 1073741824 ? 1073741824 : ss);
      c = cc < 0 ? 0 : (cc > 1073741824 ? 1073741824 : cc);
      case (quad)
         2'd0: begin sn = s; cs = c; end
         2'd1: begin sn = c; cs = -s; end
         2'd2: begin sn = -s; cs = -c; end
         default: begin sn = -c; cs = s; end
      endcase
   endfunction

   function automatic logic [31:0] turn_phase(input longint k, input longint p);
      logic [63:0] num;
      num = (64'(k) << 32) + 64'(p / 2);
      return 32'(num / 64'(p));
   endfunction

   function automatic logic [31:0] saturated_pos(input longint c, input longint rmag,
                                                  input longint n16);
      longint v;
      v = c + round_away(rmag * n16, 16);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return 32'(v);
   endfunction

   // one vertex at ring edge k
   function automatic vtx_type ring_vertex(input longint k, input longint j,
                                           input longint p, input longint slon,
                                           input longint clon, input longint rmag,
                                           input logic last);
      vtx_type v;
      longint slat, clat, nx, ny, nz;
      turn_sincos(turn_phase(k, p), clat, slat);
      slat = -slat;
      nx = round_away(clat * clon, 44);
      ny = round_away(clat * slon, 44);
      nz = round_away(slat, 14);
      v.pos_x = saturated_pos(longint'(cfg_cx), rmag, nx);
      v.pos_y = saturated_pos(longint'(cfg_cy), rmag, ny);
      v.pos_z = saturated_pos(longint'(cfg_cz), rmag, nz);
      v.normal_x = 18'(nx);
      v.normal_y = 18'(ny);
      v.normal_z = 18'(nz);
      v.tex_s = 17'((j * 65536 + p / 2) / p);
      v.tex_t = 17'((2 * k * 65536 + p / 2) / p);
      v.last_of_pair = last;
      v.off_mesh = 1'b0;
      return v;
   endfunction

   task automatic predict_pair(input longint i, input longint j);
      longint p, rmag, slon, clon;
      vtx_type v;
      p = cfg_p < 0 ? -longint'(cfg_p) : longint'(cfg_p);
      rmag = cfg_r < 0 ? -longint'(cfg_r) : longint'(cfg_r);
      if (p < 2 || p > MAX_PRECISION || i >= p / 2 || j > p) begin
         v = '0;
         v.last_of_pair = 1'b1;
         v.off_mesh = 1'b1;
         vertex_q.push_back(v);
      end else begin
         turn_sincos(turn_phase(j, p), slon, clon);
         vertex_q.push_back(ring_vertex(i + 1, j, p, slon, clon, rmag, 1'b0));
         vertex_q.push_back(ring_vertex(i, j, p, slon, clon, rmag, 1'b1));
      end
   endtask

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endtask

   // config mirror, prediction on req_ transfers, compare on rsp_ transfers
   always @(posedge clock) begin
      vtx_type w;
      if (reset) begin
         cfg_cx <= 0;
         cfg_cy <= 0;
         cfg_cz <= 0;
         cfg_r  <= 32'sd65536;
         cfg_p  <= 12'sd100;
         fail_count = 0;
         vertex_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_CENTER_X:  cfg_cx <= csr_wdata;
               REG_CENTER_Y:  cfg_cy <= csr_wdata;
               REG_CENTER_Z:  cfg_cz <= csr_wdata;
               REG_RADIUS:    cfg_r  <= csr_wdata;
               REG_PRECISION: cfg_p  <= csr_wdata[11:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            predict_pair(req_ring_index, req_segment_index);
         if (rsp_valid && rsp_ready) begin
            if (vertex_q.size() == 0) begin
               $error("vertex transfer with nothing expected");
               fail_count++;
            end else begin
               w = vertex_q.pop_front();
               check_field("pos_x", w.pos_x, rsp_pos_x);
               check_field("pos_y", w.pos_y, rsp_pos_y);
               check_field("pos_z", w.pos_z, rsp_pos_z);
               check_field("normal_x", w.normal_x, rsp_normal_x);
               check_field("normal_y", w.normal_y, rsp_normal_y);
               check_field("normal_z", w.normal_z, rsp_normal_z);
               check_field("tex_s", w.tex_s, rsp_tex_s);
               check_field("tex_t", w.tex_t, rsp_tex_t);
               check_field("last_of_pair", w.last_of_pair, rsp_last_of_pair);
               check_field("off_mesh", w.off_mesh, rsp_off_mesh);
            end
         end
      end
   end

endmodule

### dv/uv_sphere_vertex_generator_core_tb.sv
// top of the uv sphere vertex generator testbench: clock, reset, stimulus,
// idling phases and verdict; depends on uvs_pkg, uvs_checker and the core
module uv_sphere_vertex_generator_core_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import uvs_pkg::*;

   localparam int TIMEOUT_CYCLES = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [8:0]  req_ring_index = '0;
   logic [10:0] req_segment_index = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic [17:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic [16:0] rsp_tex_s, rsp_tex_t;
   logic        rsp_last_of_pair, rsp_off_mesh;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   int fail_count;
   int pending_vertices;
   int send_idle_pct = 0;
   int stall_pct = 0;
   bit hold_off = 1'b0;
   int quiet_cycles = 0;
   int cur_p = 100;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   uv_sphere_vertex_generator_core i_dut (.*);

   uvs_checker i_checker (.*);

   // receiver: random stall, or a long hold-off
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= TIMEOUT_CYCLES) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // one register write, after which the write port goes quiet
   task automatic write_reg(input csr_reg_type idx, input logic [31:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == REG_PRECISION) begin
         cur_p = $signed(value[11:0]);
         if (cur_p < 0) cur_p = -cur_p;
      end
   endtask

   // wait for all vertices, then let the pipeline drain
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_vertices != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // valid stays high into the next item unless the sender idles
   task automatic send_pair(input logic [8:0] ring, input logic [10:0] seg);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_ring_index <= ring;
      req_segment_index <= seg;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // mostly on-mesh indices, sometimes off-mesh noise
   task automatic send_random_pair();
      int half;
      half = cur_p / 2;
      if ($urandom_range(9) != 0 && half > 0 && cur_p <= MAX_PRECISION)
         send_pair(9'($urandom_range(half - 1)), 11'($urandom_range(cur_p)));
      else
         send_pair(9'($urandom), 11'($urandom));
   endtask

   task automatic random_config();
      write_reg(REG_CENTER_X, $urandom);
      write_reg(REG_CENTER_Y, $urandom_range(1) ? $urandom : $urandom_range(200000));
      write_reg(REG_CENTER_Z, $urandom);
      write_reg(REG_RADIUS, $urandom_range(1) ? $urandom : $urandom_range(1 << 22));
      write_reg(REG_PRECISION, $urandom_range(3) == 0 ? 32'($urandom_range(4095))
                : ($urandom_range(1) ? 32'($urandom_range(2, 64))
                   : -32'($urandom_range(2, 1024))));
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: corners and middle of the mesh, and off-mesh indices, at default config
      send_pair(9'd0, 11'd0);
      send_pair(9'd49, 11'd100);
      send_pair(9'd25, 11'd50);
      send_pair(9'd50, 11'd0);
      send_pair(9'd0, 11'd101);
      send_pair(9'd511, 11'd2047);
      drain();

      // extreme configuration: saturating positions, largest precision
      write_reg(REG_CENTER_X, 32'h7fff_ffff);
      write_reg(REG_CENTER_Y, 32'h8000_0000);
      write_reg(REG_CENTER_Z, 32'h7fff_ffff);
      write_reg(REG_RADIUS, 32'h8000_0000);
      write_reg(REG_PRECISION, 32'd1024);
      send_pair(9'd0, 11'd0);
      send_pair(9'd511, 11'd1024);
      send_pair(9'd256, 11'd512);
      send_pair(9'd128, 11'd1023);
      send_pair(9'd0, 11'd1025);
      drain();

      // negative precision and radius, smallest meshes, off-range precision
      write_reg(REG_RADIUS, 32'hffff_0000);
      write_reg(REG_PRECISION, 32'hffe);
      send_pair(9'd0, 11'd0);
      send_pair(9'd0, 11'd2);
      send_pair(9'd1, 11'd1);
      drain();
      write_reg(REG_PRECISION, 32'd3);
      send_pair(9'd0, 11'd3);
      drain();
      write_reg(REG_PRECISION, 32'd1);
      send_pair(9'd0, 11'd0);
      drain();
      write_reg(REG_PRECISION, 32'd1025);
      send_pair(9'd0, 11'd0);
      drain();
      write_reg(REG_PRECISION, 32'h800);
      send_pair(9'd0, 11'd0);
      drain();
      write_reg(REG_PRECISION, 32'h7ff);
      send_pair(9'd0, 11'd0);
      drain();

      // random phases over the idling modes
      for (int ph = 0; ph < 8; ph++) begin
         random_config();
         case (ph % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 87; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 87; end
            default: begin send_idle_pct = 29; stall_pct = 29; end
         endcase
         if (ph == 4) begin
            fork
               begin
                  hold_off <= 1'b1;
                  repeat (400) @(posedge clock);
                  hold_off <= 1'b0;
               end
               repeat (60) send_random_pair();
            join
         end
         repeat (80) send_random_pair();
         drain();
      end

      if (fail_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
